// File: design/mrpu_pkg.sv
// ----------------------------------------------------------------------------
// mrpu_pkg
// Types and constants shared by the RMSprop-with-momentum update pipeline.
// ----------------------------------------------------------------------------
package mrpu_pkg;

	localparam int IDX_W     = 12;
	localparam int DATA_W    = 32;
	localparam int SM_W      = 48;
	localparam int ROOT_W    = 24;
	localparam int DEN_W     = 25;
	localparam int NUM_W     = 48;
	localparam int CFG_IDX_W = 3;

	localparam logic [SM_W-1:0] SM_RESET = 48'd429496730;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARNING_RATE = 3'd0,
		REG_DECAY_RATE    = 3'd1,
		REG_MOMENTUM_RATE = 3'd2,
		REG_EPSILON       = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         param_index;
		logic signed [DATA_W-1:0] gradient;
		logic signed [DATA_W-1:0] param_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [DATA_W-1:0] new_value;
	} result_t;

endpackage

// File: design/mrpu_vunit.sv
// ----------------------------------------------------------------------------
// mrpu_vunit
// Second-moment store and its read-modify-write update with forwarding.
// ----------------------------------------------------------------------------
module mrpu_vunit #(
	parameter int DEPTH  = 4096,
	parameter int SLOT_W = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      clr_active,
	input  logic [SLOT_W-1:0]         clr_addr,
	input  logic [15:0]               decay_rate,
	input  logic                      item_valid,
	input  logic [SLOT_W-1:0]         item_slot,
	input  mrpu_pkg::item_t           item_data,
	output logic                      v_valid,
	output logic [SLOT_W-1:0]         v_slot,
	output mrpu_pkg::item_t           v_item,
	output logic [mrpu_pkg::SM_W-1:0] v_value
);
	import mrpu_pkg::*;

	logic [SM_W-1:0]   mem [DEPTH];

	logic [31:0]       g_abs;
	logic [63:0]       g_sq;
	logic [SM_W-1:0]   g2;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [SLOT_W-1:0] slot_s1, slot_s2, slot_s3, slot_s4;
	item_t             item_s1, item_s2, item_s3;
	logic [SM_W-1:0]   g2_s1;
	logic [SM_W-1:0]   rd_s1, rd_s2;
	logic [64:0]       gb_s2;
	logic [SM_W-1:0]   v_s3, v_s4;

	logic [16:0]       one_minus_beta;
	logic [64:0]       gb;
	logic [SM_W-1:0]   v_old;
	logic [63:0]       bv;
	logic [65:0]       v_sum;
	logic [49:0]       v_shr;
	logic [SM_W-1:0]   v_new;

	assign g_abs = item_data.gradient[DATA_W-1] ? (~item_data.gradient + 32'd1)
	                                            : item_data.gradient;
	assign g_sq  = g_abs * g_abs;
	assign g2    = (|g_sq[63:SM_W]) ? '1 : g_sq[SM_W-1:0];

	assign one_minus_beta = 17'h10000 - {1'b0, decay_rate};
	assign gb             = one_minus_beta * g2_s1;

	always_comb begin
		priority if (valid_s3 && slot_s3 == slot_s2) begin
			v_old = v_s3;
		end else if (valid_s4 && slot_s4 == slot_s2) begin
			v_old = v_s4;
		end else begin
			v_old = rd_s2;
		end
	end

	assign bv    = decay_rate * v_old;
	assign v_sum = {2'b00, bv} + {1'b0, gb_s2};
	assign v_shr = v_sum[65:16];
	assign v_new = (|v_shr[49:SM_W]) ? '1 : v_shr[SM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= item_slot;
			item_s1 <= item_data;
			g2_s1   <= g2;
			rd_s1   <= mem[item_slot];
			slot_s2 <= slot_s1;
			item_s2 <= item_s1;
			gb_s2   <= gb;
			rd_s2   <= rd_s1;
			slot_s3 <= slot_s2;
			item_s3 <= item_s2;
			v_s3    <= v_new;
			slot_s4 <= slot_s3;
			v_s4    <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active) begin
			mem[clr_addr] <= SM_RESET;
		end else if (adv && valid_s2) begin
			mem[slot_s2] <= v_new;
		end
	end

	assign v_valid = valid_s3;
	assign v_slot  = slot_s3;
	assign v_item  = item_s3;
	assign v_value = v_s3;

endmodule

// File: design/mrpu_sqrt.sv
// ----------------------------------------------------------------------------
// mrpu_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module mrpu_sqrt #(
	parameter int CW = 88
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [mrpu_pkg::SM_W-1:0]   radicand,
	input  logic [CW-1:0]               in_carry,
	output logic                        root_valid,
	output logic [mrpu_pkg::ROOT_W-1:0] root,
	output logic [CW-1:0]               root_carry
);
	import mrpu_pkg::*;

	localparam int N = ROOT_W;

	logic              vld_q [N];
	logic [SM_W-1:0]   v_q   [N];
	logic [ROOT_W-1:0] rt_q  [N];
	logic [ROOT_W+1:0] rm_q  [N];
	logic [CW-1:0]     cw_q  [N];

	logic [SM_W-1:0]   sv    [N];
	logic [ROOT_W-1:0] srt   [N];
	logic [ROOT_W+1:0] srm   [N];
	logic [ROOT_W+3:0] cur   [N];
	logic [ROOT_W+1:0] trial [N];
	logic [SM_W-1:0]   nv    [N];
	logic [ROOT_W-1:0] nrt   [N];
	logic [ROOT_W+1:0] nrm   [N];

	always_comb begin
		sv[0]  = radicand;
		srt[0] = '0;
		srm[0] = '0;
		for (int k = 1; k < N; k++) begin
			sv[k]  = v_q[k-1];
			srt[k] = rt_q[k-1];
			srm[k] = rm_q[k-1];
		end
		for (int k = 0; k < N; k++) begin
			cur[k]   = {srm[k], sv[k][SM_W-1 -: 2]};
			trial[k] = {srt[k], 2'b01};
			if (cur[k] >= {2'b00, trial[k]}) begin
				nrm[k] = (ROOT_W+2)'(cur[k] - {2'b00, trial[k]});
				nrt[k] = {srt[k][ROOT_W-2:0], 1'b1};
			end else begin
				nrm[k] = cur[k][ROOT_W+1:0];
				nrt[k] = {srt[k][ROOT_W-2:0], 1'b0};
			end
			nv[k] = {sv[k][SM_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cw_q[0] <= in_carry;
			for (int k = 1; k < N; k++) cw_q[k] <= cw_q[k-1];
			for (int k = 0; k < N; k++) begin
				v_q[k]  <= nv[k];
				rt_q[k] <= nrt[k];
				rm_q[k] <= nrm[k];
			end
		end
	end

	assign root_valid = vld_q[N-1];
	assign root       = rt_q[N-1];
	assign root_carry = cw_q[N-1];

endmodule

// File: design/mrpu_div.sv
// ----------------------------------------------------------------------------
// mrpu_div
// Pipelined restoring divider: gradient scaled by one over root plus epsilon.
// ----------------------------------------------------------------------------
module mrpu_div #(
	parameter int CW = 88
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic [mrpu_pkg::ROOT_W-1:0]        root,
	input  logic [15:0]                        epsilon,
	input  logic signed [mrpu_pkg::DATA_W-1:0] gradient,
	input  logic [CW-1:0]                      in_carry,
	output logic                               q_valid,
	output logic signed [mrpu_pkg::DATA_W-1:0] quotient,
	output logic [CW-1:0]                      q_carry
);
	import mrpu_pkg::*;

	localparam int N = NUM_W;

	logic             vld_s0;
	logic [DEN_W-1:0] den_s0;
	logic [NUM_W-1:0] num_s0;
	logic             neg_s0;
	logic [CW-1:0]    cw_s0;

	logic             vld_q [N];
	logic [DEN_W-1:0] den_q [N];
	logic [NUM_W-1:0] num_q [N];
	logic [NUM_W-1:0] quo_q [N];
	logic [DEN_W-1:0] rm_q  [N];
	logic             neg_q [N];
	logic [CW-1:0]    cw_q  [N];

	logic [DEN_W-1:0] sden [N];
	logic [NUM_W-1:0] snum [N];
	logic [NUM_W-1:0] squo [N];
	logic [DEN_W-1:0] srm  [N];
	logic [DEN_W:0]   cur  [N];
	logic [DEN_W-1:0] nrm  [N];
	logic [NUM_W-1:0] nquo [N];

	logic [DEN_W-1:0] den_sum;
	logic [31:0]      g_abs;
	logic [NUM_W-1:0] quo_last;

	assign den_sum = DEN_W'(root) + DEN_W'(epsilon);
	assign g_abs   = gradient[DATA_W-1] ? (~gradient + 32'd1) : gradient;

	always_comb begin
		sden[0] = den_s0;
		snum[0] = num_s0;
		squo[0] = '0;
		srm[0]  = '0;
		for (int k = 1; k < N; k++) begin
			sden[k] = den_q[k-1];
			snum[k] = num_q[k-1];
			squo[k] = quo_q[k-1];
			srm[k]  = rm_q[k-1];
		end
		for (int k = 0; k < N; k++) begin
			cur[k] = {srm[k], snum[k][NUM_W-1]};
			if (cur[k] >= {1'b0, sden[k]}) begin
				nrm[k]  = DEN_W'(cur[k] - {1'b0, sden[k]});
				nquo[k] = {squo[k][NUM_W-2:0], 1'b1};
			end else begin
				nrm[k]  = cur[k][DEN_W-1:0];
				nquo[k] = {squo[k][NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_s0   <= in_valid;
			vld_q[0] <= vld_s0;
			for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s0   <= (den_sum == '0) ? DEN_W'(1) : den_sum;
			num_s0   <= {g_abs, 16'd0};
			neg_s0   <= gradient[DATA_W-1];
			cw_s0    <= in_carry;
			neg_q[0] <= neg_s0;
			cw_q[0]  <= cw_s0;
			for (int k = 1; k < N; k++) begin
				neg_q[k] <= neg_q[k-1];
				cw_q[k]  <= cw_q[k-1];
			end
			for (int k = 0; k < N; k++) begin
				den_q[k] <= sden[k];
				num_q[k] <= {snum[k][NUM_W-2:0], 1'b0};
				quo_q[k] <= nquo[k];
				rm_q[k]  <= nrm[k];
			end
		end
	end

	assign quo_last = quo_q[N-1];

	always_comb begin
		if (neg_q[N-1]) begin
			if (quo_last >= NUM_W'(48'h8000_0000)) begin
				quotient = 32'sh8000_0000;
			end else begin
				quotient = -$signed(quo_last[DATA_W-1:0]);
			end
		end else begin
			if (quo_last > NUM_W'(48'h7FFF_FFFF)) begin
				quotient = 32'sh7FFF_FFFF;
			end else begin
				quotient = $signed(quo_last[DATA_W-1:0]);
			end
		end
	end

	assign q_valid = vld_q[N-1];
	assign q_carry = cw_q[N-1];

endmodule

// File: design/mrpu_munit.sv
// ----------------------------------------------------------------------------
// mrpu_munit
// Momentum store, its read-modify-write update and the parameter step.
// ----------------------------------------------------------------------------
module mrpu_munit #(
	parameter int DEPTH  = 4096,
	parameter int SLOT_W = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               clr_active,
	input  logic [SLOT_W-1:0]                  clr_addr,
	input  logic [15:0]                        momentum_rate,
	input  logic signed [mrpu_pkg::DATA_W-1:0] learning_rate,
	input  logic                               q_valid,
	input  logic [SLOT_W-1:0]                  q_slot,
	input  mrpu_pkg::item_t                    q_item,
	input  logic signed [mrpu_pkg::DATA_W-1:0] quotient,
	output logic                               res_valid,
	output mrpu_pkg::result_t                  res_data
);
	import mrpu_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic                     valid_s1, valid_s2, valid_s3;
	logic [SLOT_W-1:0]        slot_s1, slot_s2;
	item_t                    item_s1, item_s2, item_s3;
	logic signed [49:0]       qb_s1;
	logic signed [DATA_W-1:0] rd_s1;
	logic signed [DATA_W-1:0] m_s2;
	logic signed [63:0]       prod_s3;

	logic [16:0]              one_minus_mf;
	logic signed [49:0]       qb;
	logic signed [DATA_W-1:0] m_old;
	logic signed [48:0]       mfp;
	logic signed [50:0]       m_sum;
	logic signed [50:0]       m_bias;
	logic signed [34:0]       m_shr;
	logic signed [DATA_W-1:0] m_new;
	logic signed [63:0]       p_bias;
	logic signed [47:0]       step;
	logic signed [48:0]       nv_sum;
	logic signed [DATA_W-1:0] nv;

	assign one_minus_mf = 17'h10000 - {1'b0, momentum_rate};
	assign qb           = $signed({1'b0, one_minus_mf}) * quotient;

	assign m_old  = (valid_s2 && slot_s2 == slot_s1) ? m_s2 : rd_s1;
	assign mfp    = $signed({1'b0, momentum_rate}) * m_old;
	assign m_sum  = {{2{mfp[48]}}, mfp} + {qb_s1[49], qb_s1};
	assign m_bias = m_sum + (m_sum[50] ? 51'sd65535 : 51'sd0);
	assign m_shr  = m_bias[50:16];

	always_comb begin
		if (m_shr[34:31] == 4'b0000 || m_shr[34:31] == 4'b1111) begin
			m_new = m_shr[DATA_W-1:0];
		end else if (m_shr[34]) begin
			m_new = 32'sh8000_0000;
		end else begin
			m_new = 32'sh7FFF_FFFF;
		end
	end

	assign p_bias = prod_s3 + (prod_s3[63] ? 64'sd65535 : 64'sd0);
	assign step   = p_bias[63:16];
	assign nv_sum = 49'($signed(item_s3.param_value)) + 49'(step);

	always_comb begin
		if (nv_sum[48:31] == '0 || nv_sum[48:31] == '1) begin
			nv = nv_sum[DATA_W-1:0];
		end else if (nv_sum[48]) begin
			nv = 32'sh8000_0000;
		end else begin
			nv = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= q_slot;
			item_s1 <= q_item;
			qb_s1   <= qb;
			rd_s1   <= mem[q_slot];
			slot_s2 <= slot_s1;
			item_s2 <= item_s1;
			m_s2    <= m_new;
			item_s3 <= item_s2;
			prod_s3 <= learning_rate * m_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active) begin
			mem[clr_addr] <= '0;
		end else if (adv && valid_s1) begin
			mem[slot_s1] <= m_new;
		end
	end

	assign res_valid          = valid_s3;
	assign res_data.out_index = item_s3.param_index;
	assign res_data.new_value = nv;

endmodule

// File: design/momentum_rmsprop_param_update.sv
// ----------------------------------------------------------------------------
// momentum_rmsprop_param_update
// RMSprop-with-momentum optimizer step, one parameter per beat.
// ----------------------------------------------------------------------------
// The block takes one parameter beat per clock while item_stall is low and
// returns one result beat per item, in order, through the 24-stage square
// root and the 49-stage divider between the second-moment store and the
// momentum store. Both stores are simple dual-port synchronous memories
// with a read-modify-write loop and forwarding from the stages that still
// hold newer values, so repeated indexes run at full rate. After reset a
// clearing pass over all NUM_PARAMS addresses loads 0.1 into every second
// moment and zero into every momentum; no item is accepted during it, while
// configuration writes are taken. A two-beat output buffer lets the block
// keep taking items while a result waits.
module momentum_rmsprop_param_update #(
	parameter int NUM_PARAMS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  mrpu_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output mrpu_pkg::result_t              result,
	input  logic                           cfg_wr_en,
	input  logic [mrpu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import mrpu_pkg::*;

	localparam int SLOT_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam int CW     = SLOT_W + $bits(item_t);

	function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
		logic [31:0] r;
		r = {20'd0, idx};
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if (r >= (32'(NUM_PARAMS) << k)) r = r - (32'(NUM_PARAMS) << k);
		end
		return r[SLOT_W-1:0];
	endfunction

	logic signed [DATA_W-1:0] lr_q;
	logic [15:0]              beta_q;
	logic [15:0]              mf_q;
	logic [15:0]              eps_q;

	logic                     clr_active_q;
	logic [SLOT_W-1:0]        clr_addr_q;

	logic                     adv;
	logic                     accept;
	logic                     valid_s0;
	item_t                    item_s0;
	logic [SLOT_W-1:0]        slot_s0;

	logic                     v_valid;
	logic [SLOT_W-1:0]        v_slot;
	item_t                    v_item;
	logic [SM_W-1:0]          v_value;

	logic                     rt_valid;
	logic [ROOT_W-1:0]        rt_value;
	logic [CW-1:0]            rt_carry;
	item_t                    rt_item;

	logic                     q_valid;
	logic signed [DATA_W-1:0] q_value;
	logic [CW-1:0]            q_carry;

	logic                     res_valid;
	result_t                  res_data;

	result_t                  fifo_q [2];
	logic                     wr_ptr_q, rd_ptr_q;
	logic [1:0]               fifo_cnt_q;
	logic                     push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= '0;
			beta_q <= 16'd58982;
			mf_q   <= '0;
			eps_q  <= 16'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LEARNING_RATE: lr_q   <= $signed(cfg_data);
				REG_DECAY_RATE:    beta_q <= cfg_data[15:0];
				REG_MOMENTUM_RATE: mf_q   <= cfg_data[15:0];
				REG_EPSILON:       eps_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == SLOT_W'(NUM_PARAMS - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign adv        = (fifo_cnt_q != 2'd2);
	assign item_stall = clr_active_q || !adv;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0 <= item;
		end
	end

	assign slot_s0 = slot_of(item_s0.param_index);

	mrpu_vunit #(
		.DEPTH (NUM_PARAMS),
		.SLOT_W(SLOT_W)
	) u_vunit (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.clr_active(clr_active_q),
		.clr_addr  (clr_addr_q),
		.decay_rate(beta_q),
		.item_valid(valid_s0),
		.item_slot (slot_s0),
		.item_data (item_s0),
		.v_valid   (v_valid),
		.v_slot    (v_slot),
		.v_item    (v_item),
		.v_value   (v_value)
	);

	mrpu_sqrt #(
		.CW(CW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_valid),
		.radicand  (v_value),
		.in_carry  ({v_slot, v_item}),
		.root_valid(rt_valid),
		.root      (rt_value),
		.root_carry(rt_carry)
	);

	assign rt_item = rt_carry[$bits(item_t)-1:0];

	mrpu_div #(
		.CW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(rt_valid),
		.root    (rt_value),
		.epsilon (eps_q),
		.gradient(rt_item.gradient),
		.in_carry(rt_carry),
		.q_valid (q_valid),
		.quotient(q_value),
		.q_carry (q_carry)
	);

	mrpu_munit #(
		.DEPTH (NUM_PARAMS),
		.SLOT_W(SLOT_W)
	) u_munit (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.clr_active   (clr_active_q),
		.clr_addr     (clr_addr_q),
		.momentum_rate(mf_q),
		.learning_rate(lr_q),
		.q_valid      (q_valid),
		.q_slot       (q_carry[CW-1 -: SLOT_W]),
		.q_item       (q_carry[$bits(item_t)-1:0]),
		.quotient     (q_value),
		.res_valid    (res_valid),
		.res_data     (res_data)
	);

	assign push = adv && res_valid;
	assign pop  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= res_data;
	end

	assign result_valid = (fifo_cnt_q != 2'd0);
	assign result       = fifo_q[rd_ptr_q];

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> item_stall)
		else $error("item accepted during clearing pass");
	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !result_valid)
		else $error("result present during clearing pass");
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q != 2'd3)
		else $error("output buffer overflow");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_cnt_q == 2'd2 && result_stall) |=> fifo_cnt_q == 2'd2)
		else $error("output buffer changed while full and stalled");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Randomized regression of the RMSprop-with-momentum update block: a scoreboard
// tracks both moment stores and predicts every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mrpu_pkg::*;

	localparam int NPAR = 4096;
	localparam longint SM_TOP = 64'hFFFF_FFFF_FFFF;

	class update_scoreboard;
		logic [47:0] sm_store [NPAR];
		logic signed [31:0] mom_store [NPAR];
		logic signed [31:0] lr;
		logic [15:0] beta, mf, eps;
		result_t pending [$];
		int mismatches;
		int checked;

		function void clear();
			for (int i = 0; i < NPAR; i++) begin
				sm_store[i] = SM_RESET;
				mom_store[i] = 0;
			end
			lr = 0; beta = 16'd58982; mf = 0; eps = 16'd1;
			mismatches = 0; checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				REG_LEARNING_RATE: lr = d;
				REG_DECAY_RATE: beta = d[15:0];
				REG_MOMENTUM_RATE: mf = d[15:0];
				REG_EPSILON: eps = d[15:0];
				default: ;
			endcase
		endfunction

		function longint clip32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint unsigned root_of(longint unsigned n);
			longint unsigned r, b;
			r = 0; b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			int slot;
			longint g, p, q, m, nv, den;
			longint unsigned ag, g2, v;
			result_t r;
			slot = it.param_index % NPAR;
			g = longint'(it.gradient);
			p = longint'(it.param_value);
			ag = (g < 0) ? -g : g;
			g2 = ag * ag;
			if (g2 > SM_TOP) g2 = SM_TOP;
			v = (longint'(beta) * sm_store[slot] + (65536 - longint'(beta)) * g2) >> 16;
			if (v > SM_TOP) v = SM_TOP;
			sm_store[slot] = v;
			den = root_of(v) + eps;
			if (den == 0) den = 1;
			q = clip32((g * 65536) / den);
			m = clip32((longint'(mf) * longint'(mom_store[slot])
				+ (65536 - longint'(mf)) * q) / 65536);
			mom_store[slot] = 32'(m);
			nv = clip32(p + (longint'(lr) * m) / 65536);
			r.out_index = it.param_index;
			r.new_value = 32'(nv);
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.out_index !== exp_r.out_index || got.new_value !== exp_r.new_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: index exp %0d got %0d, value exp %h got %h",
						exp_r.out_index, got.out_index, exp_r.new_value, got.new_value);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	logic cfg_wr_en = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	update_scoreboard sb;
	bit calm = 0;
	longint cycles = 0;
	int sent = 0;

	always #2 clk = ~clk;

	momentum_rmsprop_param_update #(.NUM_PARAMS(NPAR)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
		if (arst_n && item_valid && !item_stall) sb.note_item(item);
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 15) == 0) begin
				n = $urandom_range(1, 18);
				result_stall <= 1;
				repeat (n) @(negedge clk);
				result_stall <= 0;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (cycles > 1500000) begin
				$display("momentum_rmsprop_param_update regression: fail");
				$finish;
			end
		end
	end

	task automatic send_beat(item_t it);
		int n;
		if (!calm && $urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, 18);
			item_valid <= 0;
			repeat (n) @(negedge clk);
		end
		item <= it;
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic end_burst();
		item_valid <= 0;
	endtask

	task automatic drain();
		end_burst();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_wr_en <= 1;
		@(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	function automatic item_t make_item(logic [11:0] idx, logic [31:0] g, logic [31:0] p);
		item_t it;
		it.param_index = idx; it.gradient = g; it.param_value = p;
		return it;
	endfunction

	function automatic logic [31:0] rand_grad();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 262143)) - 131072;
			2: return $signed($urandom_range(0, 2047)) - 1024;
			default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	initial begin
		static logic [31:0] lr_set [5] = '{32'hFFFF_E000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_0000, 32'h0000_4000};
		static logic [15:0] beta_set [5] = '{16'd58982, 16'd0, 16'hFFFF, 16'd32768,
			16'd65000};
		static logic [15:0] mf_set [5] = '{16'd0, 16'd58982, 16'hFFFF, 16'd0, 16'd32768};
		static logic [15:0] eps_set [5] = '{16'd1, 16'hFFFF, 16'd0, 16'd655, 16'd1};
		logic [11:0] hot [8];
		sb = new();
		sb.clear();
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		set_reg(REG_LEARNING_RATE, 32'hFFFF_F000);
		set_reg(3'd5, 32'hDEAD_BEEF);
		set_reg(3'd7, 32'h1234_5678);
		set_reg(REG_MOMENTUM_RATE, 32'd49152);

		send_beat(make_item(12'd0, 32'h0001_0000, 32'h0001_0000));
		send_beat(make_item(12'd4095, 32'h8000_0000, 32'h8000_0000));
		send_beat(make_item(12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_beat(make_item(12'd1, 32'h0, 32'hFFFF_FFFF));
		send_beat(make_item(12'd2, 32'hFFFF_FFFF, 32'h0));
		send_beat(make_item(12'd2, 32'h0000_0001, 32'h5555_5555));
		send_beat(make_item(12'd2, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
		drain();
		// zero epsilon with tiny moment: divisor falls back to one
		set_reg(REG_EPSILON, 32'd0);
		set_reg(REG_DECAY_RATE, 32'd0);
		set_reg(REG_LEARNING_RATE, 32'h7FFF_FFFF);
		send_beat(make_item(12'd10, 32'h0, 32'h0));
		send_beat(make_item(12'd10, 32'h0000_0001, 32'h0));
		send_beat(make_item(12'd11, 32'hFFFF_FFFF, 32'h7FFF_0000));
		send_beat(make_item(12'd12, 32'h8000_0000, 32'h7FFF_FFFF));
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			set_reg(REG_LEARNING_RATE, lr_set[ph]);
			set_reg(REG_DECAY_RATE, {16'd0, beta_set[ph]});
			set_reg(REG_MOMENTUM_RATE, {16'd0, mf_set[ph]});
			set_reg(REG_EPSILON, {16'd0, eps_set[ph]});
			if (ph == 4) calm = 1;
			foreach (hot[k]) hot[k] = 12'($urandom_range(0, 4095));
			for (int k = 0; k < 80; k++)
				send_beat(make_item($urandom_range(0, 2) != 0 ? hot[$urandom_range(0, 7)]
					: 12'($urandom()), rand_grad(), $urandom()));
			drain();
		end

		$display("sent %0d items over 7 register settings, checked %0d results",
			sent, sb.checked);
		$display("covered field extremes, zero divisor, hot indexes and stalls");
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("momentum_rmsprop_param_update regression: pass");
		end else begin
			$display("momentum_rmsprop_param_update regression: fail");
		end
		$finish;
	end
endmodule

// File: filelist.f
design/mrpu_pkg.sv
design/mrpu_vunit.sv
design/mrpu_sqrt.sv
design/mrpu_div.sv
design/mrpu_munit.sv
design/momentum_rmsprop_param_update.sv
sim/testbench.sv
